// ----- rtl/alm_pkg.sv -----
package alm_pkg;

  // Fixed field widths
  localparam int INDEX_W  = 3;
  localparam int PEAK_W   = 8;
  localparam int LEVEL_W  = 8;
  localparam int NEEDLE_W = 7;
  localparam int SEG_W    = 5;

  localparam int NUM_METERS_DEFAULT = 8;

  // Ballistics constants
  localparam logic [NEEDLE_W-1:0] NEEDLE_MAX     = 7'd118;
  localparam logic [LEVEL_W-1:0]  DEADBAND       = 8'd8;
  localparam logic [3:0]          STEP_TOP       = 4'd10;
  localparam logic [SEG_W-1:0]    HOLD_RELOAD    = 5'd30;
  localparam logic [LEVEL_W-1:0]  BAR_LEVEL_CAP  = 8'd128;
  localparam logic [SEG_W-1:0]    BAR_TOP_SEG    = 5'd16;
  localparam logic [SEG_W-1:0]    OVER_RANGE_SEG = 5'd14;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_NEEDLE_ENABLE = 1'b0,
    CFG_BAR_ENABLE    = 1'b1
  } cfg_idx_t;

  // Per-meter state word, one memory entry
  typedef struct packed {
    logic [NEEDLE_W-1:0] needle;
    logic [SEG_W-1:0]    bar;
    logic [SEG_W-1:0]    peak;
    logic [SEG_W-1:0]    running_peak;
    logic [SEG_W-1:0]    countdown;
  } meter_state_t;

  typedef struct packed {
    logic needle_enable;
    logic bar_enable;
  } meter_ctrl_t;

  // Needle step by distance/8, capped index
  function automatic logic [1:0] needle_step_size(input logic [3:0] idx);
    logic [1:0] step;
    case (idx)
      4'd0:                   step = 2'd0;
      4'd1, 4'd2, 4'd3:       step = 2'd1;
      4'd4, 4'd5, 4'd6,
      4'd7, 4'd8:             step = 2'd2;
      default:                step = 2'd3;
    endcase
    return step;
  endfunction

endpackage

// ----- rtl/alm_update.sv -----
module alm_update (
  input  alm_pkg::meter_ctrl_t                 ctrl,
  input  logic [alm_pkg::LEVEL_W-1:0]          level,
  input  alm_pkg::meter_state_t                cur,
  output alm_pkg::meter_state_t                upd
);

  logic                          up;
  logic [alm_pkg::LEVEL_W-1:0]   pos_ext;
  logic [alm_pkg::LEVEL_W-1:0]   distance;
  logic [4:0]                    dist_idx;
  logic [3:0]                    step_idx;
  logic [1:0]                    step;
  logic [alm_pkg::LEVEL_W-1:0]   pos_up;
  logic [alm_pkg::NEEDLE_W-1:0]  needle_new;

  logic [alm_pkg::SEG_W-1:0]     target;
  logic [alm_pkg::SEG_W-1:0]     bar_n;
  logic [alm_pkg::SEG_W-1:0]     peak_n;
  logic [alm_pkg::SEG_W-1:0]     run_n;
  logic [alm_pkg::SEG_W-1:0]     cd_n;

  // Needle: step towards level outside the deadband, clamp to range
  assign pos_ext  = {1'b0, cur.needle};
  assign up       = level > pos_ext;
  assign distance = up ? (level - pos_ext) : (pos_ext - level);
  assign dist_idx = (distance > alm_pkg::DEADBAND) ? distance[7:3] : 5'd0;
  assign step_idx = (dist_idx > {1'b0, alm_pkg::STEP_TOP}) ? alm_pkg::STEP_TOP
                                                            : dist_idx[3:0];
  assign step     = alm_pkg::needle_step_size(step_idx);
  assign pos_up   = pos_ext + {6'd0, step};

  always_comb begin
    if (up) begin
      needle_new = (pos_up > {1'b0, alm_pkg::NEEDLE_MAX}) ? alm_pkg::NEEDLE_MAX
                                                          : pos_up[6:0];
    end else begin
      needle_new = (cur.needle < {5'd0, step}) ? '0 : (cur.needle - {5'd0, step});
    end
  end

  // Bar target in segments, 0..16
  assign target = (level >= alm_pkg::BAR_LEVEL_CAP) ? alm_pkg::BAR_TOP_SEG
                                                    : {1'b0, level[6:3]};

  always_comb begin
    if (cur.countdown == '0) begin
      cd_n   = alm_pkg::HOLD_RELOAD;
      peak_n = cur.running_peak;
      run_n  = '0;
    end else begin
      cd_n   = cur.countdown - 5'd1;
      peak_n = cur.peak;
      run_n  = (cur.bar > cur.running_peak) ? cur.bar : cur.running_peak;
    end
    bar_n = cur.bar;
    if (target > cur.bar) begin
      bar_n = target;
      if (peak_n < target) peak_n = target;
    end else if (target < cur.bar) begin
      bar_n = cur.bar - 5'd1;
    end
  end

  always_comb begin
    upd = cur;
    if (ctrl.needle_enable) upd.needle = needle_new;
    if (ctrl.bar_enable) begin
      upd.bar          = bar_n;
      upd.peak         = peak_n;
      upd.running_peak = run_n;
      upd.countdown    = cd_n;
    end
  end

endmodule

// ----- rtl/audio_level_meter_ballistics_core.sv -----
// Level meter ballistics: VU needle plus segment bar with peak hold, one state
// set per meter, held in a single state memory.
// Request channel (req_valid/req_ready): meter_index, high_peak, low_peak.
// Result channel (rsp_valid/rsp_ready): meter_echo, needle_position,
//   bar_segments, peak_segment, peak_over_range; exactly one per request.
// Config: cfg_write with cfg_index 0 = needle enable, 1 = bar/peak enable.
//   Write only while no request is in flight.
// Result path: the edge that takes the request registers the memory read;
//   the update then loads the result register once that register is free,
//   and rsp_valid rises with it.
// Throughput: one request per cycle unless a result stalls, any meter order; a request for the meter
//   just updated takes the written-back word from a forwarding register.
//   The rate is set by the single read-modify-write pass through the memory.
// Reset: all meters read as zero state (per-entry valid flags cleared), both
//   enables set, no result pending. No clearing pass is needed.
// Stall: while a result waits unaccepted the update stage holds; req_ready
//   stays high as long as the update stage is empty or can move on.
// A meter index at or above NUM_METERS leaves state untouched and returns
//   zero fields with the index echoed.
module audio_level_meter_ballistics_core #(
  parameter int NUM_METERS = alm_pkg::NUM_METERS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  // request
  input  logic                           req_valid,
  output logic                           req_ready,
  input  logic [alm_pkg::INDEX_W-1:0]    meter_index,
  input  logic signed [alm_pkg::PEAK_W-1:0] high_peak,
  input  logic signed [alm_pkg::PEAK_W-1:0] low_peak,
  // result
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output logic [alm_pkg::INDEX_W-1:0]    meter_echo,
  output logic [alm_pkg::NEEDLE_W-1:0]   needle_position,
  output logic [alm_pkg::SEG_W-1:0]      bar_segments,
  output logic [alm_pkg::SEG_W-1:0]      peak_segment,
  output logic                           peak_over_range,
  // configuration
  input  logic                           cfg_write,
  input  logic [0:0]                     cfg_index,
  input  logic [0:0]                     cfg_data
);

  localparam int AW = (NUM_METERS > 1) ? $clog2(NUM_METERS) : 1;

  // ---------------------------------------------------------------- config
  alm_pkg::meter_ctrl_t ctrl;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.needle_enable <= 1'b1;
      ctrl.bar_enable    <= 1'b1;
    end else if (cfg_write) begin
      unique case (alm_pkg::cfg_idx_t'(cfg_index))
        alm_pkg::CFG_NEEDLE_ENABLE: ctrl.needle_enable <= cfg_data[0];
        alm_pkg::CFG_BAR_ENABLE:    ctrl.bar_enable    <= cfg_data[0];
      endcase
    end
  end

  // ---------------------------------------------------------- request side
  logic                          req_take;
  logic [AW+alm_pkg::INDEX_W-1:0] req_addr_wide;
  logic [AW-1:0]                 req_addr;
  logic                          req_in_range;
  logic signed [alm_pkg::PEAK_W:0] hi_ext;
  logic signed [alm_pkg::PEAK_W:0] lo_neg;
  logic signed [alm_pkg::PEAK_W:0] big;

  assign req_take      = req_valid && req_ready;
  assign req_addr_wide = {{AW{1'b0}}, meter_index};
  assign req_addr      = req_addr_wide[AW-1:0];
  assign req_in_range  = int'(meter_index) < NUM_METERS;

  // level = max(high, -low), kept to 8 bits (a negative maximum wraps)
  assign hi_ext = {high_peak[alm_pkg::PEAK_W-1], high_peak};
  assign lo_neg = -{low_peak[alm_pkg::PEAK_W-1], low_peak};
  assign big    = (hi_ext > lo_neg) ? hi_ext : lo_neg;

  // ------------------------------------------------------- update stage
  logic                          s1_valid;
  logic                          s1_advance;
  logic [AW-1:0]                 s1_addr;
  logic [alm_pkg::INDEX_W-1:0]   s1_index;
  logic [alm_pkg::LEVEL_W-1:0]   s1_level;
  logic                          s1_in_range;
  logic                          s1_entry_valid;
  logic                          s1_fwd;
  alm_pkg::meter_state_t         s1_fwd_data;
  alm_pkg::meter_state_t         rd_data;
  alm_pkg::meter_state_t         cur_state;
  alm_pkg::meter_state_t         upd_state;
  logic                          wr_en;

  alm_pkg::meter_state_t         state_mem [NUM_METERS];
  logic [NUM_METERS-1:0]         entry_valid;

  assign s1_advance = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready  = !s1_valid || !rsp_valid || rsp_ready;
  assign wr_en      = s1_advance && s1_in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_take) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  // Stage payload; the forwarding flag catches a write to the same meter
  // landing on the edge the memory is read.
  always_ff @(posedge clk) begin
    if (req_take) begin
      s1_addr        <= req_addr;
      s1_index       <= meter_index;
      s1_level       <= big[alm_pkg::LEVEL_W-1:0];
      s1_in_range    <= req_in_range;
      s1_entry_valid <= entry_valid[req_addr];
      s1_fwd         <= wr_en && (s1_addr == req_addr);
      s1_fwd_data    <= upd_state;
    end
  end

  // State memory: one read port, one write port, registered read data
  always_ff @(posedge clk) begin
    if (req_take) rd_data <= state_mem[req_addr];
    if (wr_en) state_mem[s1_addr] <= upd_state;
  end

  // Entries never written read as zero state
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (wr_en) begin
      entry_valid[s1_addr] <= 1'b1;
    end
  end

  always_comb begin
    priority if (s1_fwd) cur_state = s1_fwd_data;
    else if (s1_entry_valid) cur_state = rd_data;
    else cur_state = '0;
  end

  alm_update u_update (
    .ctrl  (ctrl),
    .level (s1_level),
    .cur   (cur_state),
    .upd   (upd_state)
  );

  // --------------------------------------------------------- result side
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      meter_echo <= s1_index;
      if (s1_in_range) begin
        needle_position <= upd_state.needle;
        bar_segments    <= upd_state.bar;
        peak_segment    <= upd_state.peak;
        peak_over_range <= upd_state.peak > alm_pkg::OVER_RANGE_SEG;
      end else begin
        needle_position <= '0;
        bar_segments    <= '0;
        peak_segment    <= '0;
        peak_over_range <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/alm_checker.sv -----
module alm_checker #(
  parameter int NUM_METERS = alm_pkg::NUM_METERS_DEFAULT
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [alm_pkg::INDEX_W-1:0]   meter_echo,
  input logic [alm_pkg::NEEDLE_W-1:0]  needle_position,
  input logic [alm_pkg::SEG_W-1:0]     bar_segments,
  input logic [alm_pkg::SEG_W-1:0]     peak_segment,
  input logic                          peak_over_range
);

  // No result straight out of reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(needle_position)
      && $stable(bar_segments) && $stable(peak_segment))
    else $error("stalled result dropped or changed");

  // Over-range flag tracks the held peak
  a_over_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (peak_over_range == (peak_segment > alm_pkg::OVER_RANGE_SEG)))
    else $error("over-range flag mismatch");

  // Unknown meter returns zero fields
  a_unknown_meter: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (int'(meter_echo) >= NUM_METERS) |->
      needle_position == '0 && bar_segments == '0 && peak_segment == '0)
    else $error("unknown meter returned state");

  // Results stay within meter ranges
  a_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> needle_position <= alm_pkg::NEEDLE_MAX
      && bar_segments <= alm_pkg::BAR_TOP_SEG && peak_segment <= alm_pkg::BAR_TOP_SEG)
    else $error("result out of range");

endmodule

bind audio_level_meter_ballistics_core alm_checker #(.NUM_METERS(NUM_METERS)) u_alm_checker (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp_valid),
  .rsp_ready       (rsp_ready),
  .meter_echo      (meter_echo),
  .needle_position (needle_position),
  .bar_segments    (bar_segments),
  .peak_segment    (peak_segment),
  .peak_over_range (peak_over_range)
);

// ----- tb/audio_level_meter_ballistics_core_tb.sv -----
module audio_level_meter_ballistics_core_tb;

  localparam int INDEX_W        = alm_pkg::INDEX_W;
  localparam int PEAK_W         = alm_pkg::PEAK_W;
  localparam int NEEDLE_W       = alm_pkg::NEEDLE_W;
  localparam int SEG_W          = alm_pkg::SEG_W;
  localparam int METERS         = alm_pkg::NUM_METERS_DEFAULT;
  // ballistics figures, kept as plain ints so that the sums below stay signed
  localparam int NEEDLE_TOP     = 118;
  localparam int DEAD_ZONE      = 8;
  localparam int STEP_INDEX_TOP = 10;
  localparam int HOLD_LOAD      = 30;
  localparam int LEVEL_CAP      = 128;
  localparam int OVER_SEG       = 14;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int LONG_STALL     = 200;

  // one result as the block should present it
  typedef struct packed {
    logic [INDEX_W-1:0]  meter;
    logic [NEEDLE_W-1:0] needle;
    logic [SEG_W-1:0]    bar;
    logic [SEG_W-1:0]    peak;
    logic                over;
  } meter_reading_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      req_valid = 1'b0;
  logic                      req_ready;
  logic [INDEX_W-1:0]        meter_index = '0;
  logic signed [PEAK_W-1:0]  high_peak = '0;
  logic signed [PEAK_W-1:0]  low_peak = '0;
  logic                      rsp_valid;
  logic                      rsp_ready = 1'b0;
  logic [INDEX_W-1:0]        meter_echo;
  logic [NEEDLE_W-1:0]       needle_position;
  logic [SEG_W-1:0]          bar_segments;
  logic [SEG_W-1:0]          peak_segment;
  logic                      peak_over_range;
  logic                      cfg_write = 1'b0;
  logic [0:0]                cfg_index = '0;
  logic [0:0]                cfg_data = '0;

  // shadow of the block: enables and per-meter state
  logic                needle_on;
  logic                bar_on;
  logic [NEEDLE_W-1:0] needle_mem  [METERS];
  logic [SEG_W-1:0]    bar_mem     [METERS];
  logic [SEG_W-1:0]    peak_mem    [METERS];
  logic [SEG_W-1:0]    run_peak_mem[METERS];
  logic [SEG_W-1:0]    hold_mem    [METERS];
  int                  step_by_index [0:10] = '{0, 1, 1, 1, 2, 2, 2, 2, 2, 3, 3};

  meter_reading_t readings_due[$];
  meter_reading_t oldest;
  int             mismatches = 0;
  int             items_sent = 0;
  int             cycle_count = 0;

  // receiver controls: calm suppresses random idling on both sides,
  // bumping stall_order asks the receiver for one long hold-off
  bit calm = 1'b0;
  int stall_order = 0;
  int stall_seen = 0;
  int hold_left = 0;

  audio_level_meter_ballistics_core #(
    .NUM_METERS(METERS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .meter_index(meter_index),
    .high_peak(high_peak),
    .low_peak(low_peak),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .meter_echo(meter_echo),
    .needle_position(needle_position),
    .bar_segments(bar_segments),
    .peak_segment(peak_segment),
    .peak_over_range(peak_over_range),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic void clear_meters();
    needle_on = 1'b1;
    bar_on    = 1'b1;
    for (int i = 0; i < METERS; i++) begin
      needle_mem[i]   = '0;
      bar_mem[i]      = '0;
      peak_mem[i]     = '0;
      run_peak_mem[i] = '0;
      hold_mem[i]     = '0;
    end
  endfunction

  // Advances the shadow state of one meter by one request and returns the
  // reading the block should report for it.
  function automatic meter_reading_t update_meter(input logic [INDEX_W-1:0] m,
                                                  input logic signed [PEAK_W-1:0] hi,
                                                  input logic signed [PEAK_W-1:0] lo);
    meter_reading_t r;
    int amp, level, pos, idx, tgt, bar;
    amp   = (int'(hi) > -int'(lo)) ? int'(hi) : -int'(lo);
    level = amp & 255;               // negative amplitudes wrap to high levels
    r = '0;
    r.meter = m;
    if (int'(m) >= METERS) return r; // out-of-range meter: echo only

    if (needle_on) begin
      pos = int'(needle_mem[m]);
      idx = 0;
      if (level > pos) begin
        if (level > pos + DEAD_ZONE) idx = (level - pos) >> 3;
        if (idx > STEP_INDEX_TOP) idx = STEP_INDEX_TOP;
        pos = pos + step_by_index[idx];
        if (pos > NEEDLE_TOP) pos = NEEDLE_TOP;
      end else begin
        if (level < pos - DEAD_ZONE) idx = (pos - level) >> 3;
        if (idx > STEP_INDEX_TOP) idx = STEP_INDEX_TOP;
        pos = pos - step_by_index[idx];
        if (pos < 0) pos = 0;
      end
      needle_mem[m] = NEEDLE_W'(pos);
    end

    if (bar_on) begin
      bar = int'(bar_mem[m]);
      // hold countdown: reload publishes the running peak, else track the
      // bar as it stood before this request
      if (hold_mem[m] == 0) begin
        hold_mem[m]     = SEG_W'(HOLD_LOAD);
        peak_mem[m]     = run_peak_mem[m];
        run_peak_mem[m] = '0;
      end else begin
        hold_mem[m] = hold_mem[m] - SEG_W'(1);
        if (bar > int'(run_peak_mem[m])) run_peak_mem[m] = SEG_W'(bar);
      end
      tgt = ((level > LEVEL_CAP) ? LEVEL_CAP : level) >> 3;
      if (tgt > bar) begin
        bar = tgt;                   // instant attack, may lift the held peak
        if (int'(peak_mem[m]) < bar) peak_mem[m] = SEG_W'(bar);
      end else if (tgt < bar) begin
        bar = bar - 1;               // one segment of release per request
      end
      bar_mem[m] = SEG_W'(bar);
    end

    r.needle = needle_mem[m];
    r.bar    = bar_mem[m];
    r.peak   = peak_mem[m];
    r.over   = (int'(peak_mem[m]) > OVER_SEG);
    return r;
  endfunction

  function automatic void compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Monitor: sampled on the rising edge, so only settled values are seen.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (readings_due.size() == 0) begin
          $error("result for meter %0d with no request outstanding", meter_echo);
          mismatches++;
        end else begin
          oldest = readings_due.pop_front();
          compare_field("meter_echo", int'(oldest.meter), int'(meter_echo));
          compare_field("needle_position", int'(oldest.needle), int'(needle_position));
          compare_field("bar_segments", int'(oldest.bar), int'(bar_segments));
          compare_field("peak_segment", int'(oldest.peak), int'(peak_segment));
          compare_field("peak_over_range", int'(oldest.over), int'(peak_over_range));
        end
      end
      if (req_valid && req_ready)
        readings_due.push_back(update_meter(meter_index, high_peak, low_peak));
      if (cfg_write) begin
        case (cfg_index)
          alm_pkg::CFG_NEEDLE_ENABLE: needle_on = cfg_data[0];
          alm_pkg::CFG_BAR_ENABLE:    bar_on    = cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // Receiver: random back-pressure, a quiet stretch, and on demand one long
  // hold-off counted here in cycles.
  always @(negedge clk) begin
    if (stall_seen != stall_order) begin
      stall_seen = stall_order;
      hold_left  = LONG_STALL;
    end
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rsp_ready <= 1'b0;
    end else if (calm) begin
      rsp_ready <= 1'b1;
    end else begin
      rsp_ready <= ($urandom_range(0, 9) != 0);
    end
  end

  // Offers one request from a falling edge and returns at the falling edge
  // after it is taken; valid stays high so back-to-back requests have no gap.
  task automatic send_request(input logic [INDEX_W-1:0] m,
                              input logic signed [PEAK_W-1:0] h,
                              input logic signed [PEAK_W-1:0] l);
    if (!calm && $urandom_range(0, 19) == 0) begin
      req_valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    req_valid   = 1'b1;
    meter_index = m;
    high_peak   = h;
    low_peak    = l;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Peak pair whose larger magnitude is exactly amp (0..128).
  task automatic send_level(input int m, input int amp);
    int hi, lo;
    if (amp >= LEVEL_CAP) begin
      lo = -LEVEL_CAP;
      hi = int'($urandom_range(0, 255)) - 128;
    end else if ($urandom_range(0, 1) == 0) begin
      hi = amp;
      lo = -int'($urandom_range(0, amp));
    end else begin
      lo = -amp;
      hi = int'($urandom_range(0, 2 * amp)) - amp;
    end
    send_request(m[INDEX_W-1:0], hi[PEAK_W-1:0], lo[PEAK_W-1:0]);
  endtask

  task automatic send_noise();
    logic [INDEX_W-1:0] m;
    logic [PEAK_W-1:0]  h, l;
    m = INDEX_W'($urandom_range(0, METERS - 1));
    h = PEAK_W'($urandom_range(0, 255));
    l = PEAK_W'($urandom_range(0, 255));
    send_request(m, h, l);
  endtask

  // Attack / hold / release burst, mostly on one meter with another mixed in,
  // so the same meter often comes back to back.
  task automatic play_envelope();
    int m_a, m_b, top, n_att, n_hold, n_rel, amp;
    m_a = $urandom_range(0, METERS - 1);
    m_b = $urandom_range(0, METERS - 1);
    case ($urandom_range(0, 3))
      0:       top = LEVEL_CAP;
      1:       top = $urandom_range(100, 127);
      default: top = $urandom_range(0, 127);
    endcase
    n_att  = $urandom_range(1, 8);
    n_hold = $urandom_range(0, 30);
    n_rel  = $urandom_range(1, 40);
    for (int k = 0; k < n_att + n_hold + n_rel; k++) begin
      if (k < n_att)
        amp = top * (k + 1) / n_att;
      else if (k < n_att + n_hold)
        amp = top - int'($urandom_range(0, top / 8));
      else
        amp = top * (n_att + n_hold + n_rel - k - 1) / n_rel;
      send_level(($urandom_range(0, 3) == 0) ? m_b : m_a, amp);
    end
  endtask

  // Mostly envelopes, with bursts of raw random bytes (wrapped levels).
  task automatic run_mixed(input int n);
    int start;
    start = items_sent;
    while (items_sent - start < n) begin
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 5)) send_noise();
      else
        play_envelope();
    end
  endtask

  task automatic wait_idle();
    req_valid = 1'b0;
    while (readings_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);       // two-stage pipeline, plus margin
  endtask

  task automatic set_register(input alm_pkg::cfg_idx_t idx, input logic val);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // Field extremes, level wrap, deadband edge, full-scale bar and over-range.
  task automatic test_directed();
    send_request(3'd0, 8'sd0, 8'sd0);        // first request: hold reload path
    send_request(3'd0, 8'sd8, 8'sd0);        // exactly on the deadband
    send_request(3'd0, 8'sd9, 8'sd0);        // just past it
    send_request(3'd1, 8'sd127, 8'sh80);     // -low of -128 gives 128
    send_request(3'd1, 8'sd127, 8'sd0);      // bar falls by one
    send_request(3'd2, -8'sd3, 8'sd3);       // negative level wraps to 253
    send_request(3'd2, 8'sh80, 8'sd127);     // wraps to 129
    send_request(3'd3, 8'sh80, 8'sh80);
    send_request(3'd3, 8'sd127, 8'sd127);
    send_request(3'd4, -8'sd1, 8'sd1);       // wraps to 255
    send_request(3'd4, 8'sh80, -8'sd1);
    send_request(3'd5, 8'sh55, 8'shAA);
    send_request(3'd6, 8'shAA, 8'sh55);
    repeat (6) send_request(3'd7, 8'sd127, 8'sd0);
    repeat (3) send_request(3'd7, 8'sd0, 8'sd0);
    send_request(3'd7, 8'sd0, 8'sd127);
  endtask

  // Each enable off on its own, both off, then both back on.
  task automatic test_frozen_parts();
    wait_idle();
    set_register(alm_pkg::CFG_NEEDLE_ENABLE, 1'b0);
    run_mixed(120);
    wait_idle();
    set_register(alm_pkg::CFG_NEEDLE_ENABLE, 1'b1);
    set_register(alm_pkg::CFG_BAR_ENABLE, 1'b0);
    run_mixed(120);
    wait_idle();
    set_register(alm_pkg::CFG_NEEDLE_ENABLE, 1'b0);
    run_mixed(80);
    wait_idle();
    set_register(alm_pkg::CFG_NEEDLE_ENABLE, 1'b1);
    set_register(alm_pkg::CFG_BAR_ENABLE, 1'b1);
  endtask

  // Bulk traffic; the first stretch runs with no idling on either side.
  task automatic test_random_traffic();
    calm = 1'b1;
    run_mixed(300);
    calm = 1'b0;
    run_mixed(1150);
  endtask

  // Receiver holds off for a long stretch while requests keep coming, so the
  // pipeline fills and req_ready has to drop.
  task automatic test_output_backpressure();
    calm = 1'b1;
    stall_order++;
    run_mixed(120);
    calm = 1'b0;
  endtask

  initial begin
    clear_meters();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_frozen_parts();
    test_random_traffic();
    test_output_backpressure();

    wait_idle();
    repeat (10) @(negedge clk);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
